[src/pts_sorted_frame_reorder_queue_defines.svh]
// Assertion macros for the frame reorder queue checker.
// Depends on nothing; taken in by the checker file.
`ifndef PTS_SORTED_FRAME_REORDER_QUEUE_DEFINES_SVH
`define PTS_SORTED_FRAME_REORDER_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PRFQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prfq assertion failed");

// Next-cycle implication.
`define PRFQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prfq assertion failed");

`endif

[src/prfq_pkg.sv]
// Shared types and constants for the frame reorder queue.
// Depends on nothing; used by the cell, the top level and the checker.
package prfq_pkg;

	localparam int PRFQ_QUEUE_DEPTH = 16;
	localparam int STAMP_W = 48;
	localparam int HANDLE_W = 32;
	localparam int DEPTH_W = 4;
	localparam int OCC_W = 5;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd2;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_MARK   = 2'd1,
		ACT_POP    = 2'd2,
		ACT_FLUSH  = 2'd3
	} action_t;

	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_REFUSED = 3'd1;
	localparam logic [2:0] STS_NOT_RDY = 3'd2;
	localparam logic [2:0] STS_NO_STMP = 3'd3;
	localparam logic [2:0] STS_DROPPED = 3'd4;

	typedef struct packed {
		logic                valid;
		logic                ready;
		logic [STAMP_W-1:0]  stamp;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	// Per-cycle command broadcast to every cell; op bits are already qualified.
	typedef struct packed {
		logic                ins;
		logic                mark;
		logic                pop;
		logic                flush;
		logic [STAMP_W-1:0]  stamp;
		logic [HANDLE_W-1:0] handle;
	} cell_ctl_t;

endpackage

[src/prfq_cell.sv]
// One slot of the sorted queue: holds an entry, compares it against the command
// stamp, and takes from its left or right neighbor on insert or pop. Uses prfq_pkg.
module prfq_cell import prfq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	input  logic      left_keep,
	input  logic      left_match,
	output entry_t    entry,
	output logic      keep,
	output logic      match
);

	logic                valid_q;
	logic                ready_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [HANDLE_W-1:0] handle_q;
	entry_t              cur_entry;
	entry_t              entry_d;
	logic                first;

	assign cur_entry = '{valid: valid_q, ready: ready_q, stamp: stamp_q, handle: handle_q};

	// Entries are sorted, so equal stamps sit in one run; its head has no match on the left.
	assign keep  = cur_entry.valid && ($signed(cur_entry.stamp) <= $signed(ctl.stamp));
	assign match = cur_entry.valid && (cur_entry.stamp == ctl.stamp);
	assign first = match && !left_match;
	assign entry = cur_entry;

	always_comb begin
		entry_d = cur_entry;
		priority if (ctl.flush) begin
			entry_d.valid = 1'b0;
			entry_d.ready = 1'b0;
		end else if (ctl.ins) begin
			if (!keep) begin
				if (left_keep) begin
					entry_d.valid  = 1'b1;
					entry_d.ready  = 1'b0;
					entry_d.stamp  = ctl.stamp;
					entry_d.handle = '0;
				end else begin
					entry_d = left_entry;
				end
			end
		end else if (ctl.pop) begin
			entry_d = right_entry;
		end else if (ctl.mark && first) begin
			entry_d.ready  = 1'b1;
			entry_d.handle = ctl.handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ready_q <= 1'b0;
		end else begin
			valid_q <= entry_d.valid;
			ready_q <= entry_d.ready;
		end
	end

	always_ff @(posedge clk) begin
		stamp_q  <= entry_d.stamp;
		handle_q <= entry_d.handle;
	end

endmodule

[src/pts_sorted_frame_reorder_queue.sv]
// An accepted item is held in the command register (busy) while it drives the row of
// cells, and done, status and the outputs are registered from it. A new item is not
// taken while busy; all cells update at the end of the busy cycle.
// Reset clears the entry count, all valid/ready bits and sets reorder_depth to 2.
// Results cannot be stalled; done is a one-cycle strobe.
// Uses prfq_pkg and prfq_cell.
module pts_sorted_frame_reorder_queue import prfq_pkg::*; #(
	parameter int QUEUE_DEPTH = PRFQ_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic signed [STAMP_W-1:0]  stamp,
	input  logic [HANDLE_W-1:0]        frame_handle,
	input  logic                       dropped,
	input  logic                       reorder_depth_we,
	input  logic [DEPTH_W-1:0]         reorder_depth_wdata,
	output logic                       done,
	output logic [2:0]                 status,
	output logic signed [STAMP_W-1:0]  out_stamp,
	output logic [HANDLE_W-1:0]        out_handle,
	output logic [OCC_W-1:0]           occupancy
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                 vld_s1;
	action_t              act_s1;
	logic [STAMP_W-1:0]   stamp_s1;
	logic [HANDLE_W-1:0]  handle_s1;
	logic                 dropped_s1;

	logic [DEPTH_W-1:0]   depth_q;
	logic [CNT_W-1:0]     count_q;
	logic                 done_q;
	logic [2:0]           status_q;
	logic [STAMP_W-1:0]   out_stamp_q;
	logic [HANDLE_W-1:0]  out_handle_q;

	entry_t                 ent [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] keep_v;
	logic [QUEUE_DEPTH-1:0] match_v;
	cell_ctl_t              ctl;

	logic       refuse;
	logic       pop_ok;
	logic       any_match;
	logic [2:0] status_d;

	assign busy = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			act_s1     <= action_t'(action);
			stamp_s1   <= stamp;
			handle_s1  <= frame_handle;
			dropped_s1 <= dropped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (reorder_depth_we) begin
			depth_q <= reorder_depth_wdata;
		end
	end

	assign refuse = (32'(count_q) > 32'(depth_q)) || (32'(count_q) >= QUEUE_DEPTH);
	assign pop_ok = (count_q != '0) && (32'(count_q) > 32'(depth_q)) && ent[0].ready;
	assign any_match = |match_v;

	always_comb begin
		ctl.ins    = vld_s1 && (act_s1 == ACT_INSERT) && !refuse;
		ctl.mark   = vld_s1 && (act_s1 == ACT_MARK) && !dropped_s1;
		ctl.pop    = vld_s1 && (act_s1 == ACT_POP) && pop_ok;
		ctl.flush  = vld_s1 && (act_s1 == ACT_FLUSH);
		ctl.stamp  = stamp_s1;
		ctl.handle = handle_s1;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_k;
		logic   left_m;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_k = 1'b1;
			assign left_m = 1'b0;
		end else begin : g_body
			assign left_e = ent[i-1];
			assign left_k = keep_v[i-1];
			assign left_m = match_v[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_mid
			assign right_e = ent[i+1];
		end

		prfq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_entry  (left_e),
			.right_entry (right_e),
			.left_keep   (left_k),
			.left_match  (left_m),
			.entry       (ent[i]),
			.keep        (keep_v[i]),
			.match       (match_v[i])
		);
	end

	always_comb begin
		unique case (act_s1)
			ACT_INSERT: status_d = refuse ? STS_REFUSED : STS_OK;
			ACT_MARK: begin
				if (dropped_s1) begin
					status_d = STS_DROPPED;
				end else begin
					status_d = any_match ? STS_OK : STS_NO_STMP;
				end
			end
			ACT_POP:   status_d = pop_ok ? STS_OK : STS_NOT_RDY;
			ACT_FLUSH: status_d = STS_OK;
			default:   status_d = STS_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= vld_s1;
			priority if (ctl.flush) begin
				count_q <= '0;
			end else if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			status_q     <= status_d;
			out_stamp_q  <= ctl.pop ? ent[0].stamp : '0;
			out_handle_q <= ctl.pop ? ent[0].handle : '0;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign out_stamp  = out_stamp_q;
	assign out_handle = out_handle_q;
	assign occupancy  = OCC_W'(count_q);

endmodule

[src/prfq_checker.sv]
// Port-level checker for the frame reorder queue, bound to the top level.
// Uses prfq_pkg and the assertion macros header.
`include "pts_sorted_frame_reorder_queue_defines.svh"

module prfq_checker import prfq_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [2:0]                status,
	input logic signed [STAMP_W-1:0] out_stamp,
	input logic [HANDLE_W-1:0]       out_handle
);

	// An accepted item sets busy, and a busy cycle is always followed by an idle one.
	`PRFQ_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`PRFQ_ASSERT_NXT(a_busy_one, clk, arst_n, busy, !busy)
	// A result strobe follows a busy cycle and nothing else.
	`PRFQ_ASSERT_NOW(a_done_after_busy, clk, arst_n, done, $past(busy))
	// Payload is zero on any result whose status is not OK.
	`PRFQ_ASSERT_NOW(a_zero_payload, clk, arst_n, done && (status != STS_OK),
		(out_stamp == '0) && (out_handle == '0))

endmodule

bind pts_sorted_frame_reorder_queue prfq_checker u_prfq_checker (.*);
